// File: rtl/core/ictf_pkg.sv
// Shared types, constants and helpers for the complementary tilt filter.
package ictf_pkg;

    localparam int EST_W     = 26;   // estimate width, 2^-16 degree units
    localparam int ANG_W     = 27;   // CORDIC angle accumulator width
    localparam int CV_W      = 28;   // CORDIC vector component width
    localparam int SUM_W     = 46;   // blend accumulator width
    localparam int ATAN_LEN  = 24;   // entries in the arctangent table

    localparam logic [1:0] REG_BLEND_WEIGHT = 2'd0;
    localparam logic [1:0] REG_GYRO_STEP    = 2'd1;

    localparam logic [16:0] BLEND_RESET = 17'd64225;
    localparam logic [15:0] STEP_RESET  = 16'd2561;
    localparam logic [16:0] WEIGHT_ONE  = 17'd65536;

    localparam logic signed [ANG_W-1:0] HALF_TURN = 27'sd11796480;

    // atan(2^-i) in 2^-16 degree units, rounded to nearest
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // saturate a wide signed value to the estimate range
    function automatic logic signed [EST_W-1:0] sat_est(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(33554431);
        lo = -SUM_W'(33554432);
        if (v > hi) begin
            return EST_W'(33554431);
        end else if (v < lo) begin
            return EST_W'(-33554432);
        end
        return v[EST_W-1:0];
    endfunction

endpackage

// File: rtl/core/ictf_isqrt.sv
// Iterative integer square root, two radicand bits per pass, one pass per cycle.
module ictf_isqrt
    import ictf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic [15:0] root,
    output logic        done
);

    logic [31:0] n_reg, n_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb begin
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            n_next    = radicand;
            res_next  = '0;
            bit_next  = 32'h4000_0000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, n_reg} >= trial) begin
                n_next   = n_reg - trial[31:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 32'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root = res_reg[15:0];
    assign done = done_reg;

endmodule

// File: rtl/core/ictf_cordic.sv
// Vectoring CORDIC atan2, one rotation step per cycle.
module ictf_cordic
    import ictf_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [16:0]      y_in,
    input  logic signed [16:0]      x_in,
    output logic signed [ANG_W-1:0] angle,
    output logic                    done
);

    localparam int NUM = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

    logic signed [CV_W-1:0]  x_reg, x_next;
    logic signed [CV_W-1:0]  y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [CV_W-1:0]  xs, ys, x0, y0;
    logic signed [ANG_W-1:0] step_ang;

    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign step_ang = ANG_W'($signed({1'b0, atan_entry(cnt_reg)}));
    assign x0       = CV_W'(x_in) <<< 8;
    assign y0       = CV_W'(y_in) <<< 8;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = '0;
            if (x_in == '0 && y_in == '0) begin
                z_next    = '0;
                done_next = 1'b1;
            end else if (x_in < 0) begin
                x_next    = -x0;
                y_next    = -y0;
                z_next    = (y_in > 0) ? HALF_TURN : -HALF_TURN;
                busy_next = 1'b1;
            end else begin
                x_next    = x0;
                y_next    = y0;
                z_next    = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(NUM - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign angle = z_reg;
    assign done  = done_reg;

endmodule

// File: rtl/core/imu_complementary_tilt_filter.sv
// Top level of the complementary pitch/roll tilt filter.
// Each transfer on the s_ channel carries one raw sample set (three
// accelerometer axes, two gyro axes). The block derives accelerometer pitch
// and roll with atan2 (integer square root plus a vectoring CORDIC), blends
// each with the gyro-integrated previous estimate and delivers both filtered
// angles, in 1/128 degree, as one transfer on the m_ channel. Per sample the
// sequencer runs the accept step, the two squares, the 16-pass square root,
// the two CORDIC runs on one shared rotator, the blend of both axes on one
// shared 27x18 multiplier and the output load. s_ready is high only while the
// sequencer is idle; a finished result waits in the output register and does
// not block acceptance of the next sample, though that sample's result holds
// in ST_OUT until the register frees. Write cfg_ registers only while idle.
module imu_complementary_tilt_filter
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_pitch_angle,
    output logic signed [16:0] m_roll_angle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQZ, ST_ROOT_GO, ST_ROOT_WAIT,
        ST_PCOR_GO, ST_PCOR_WAIT, ST_RCOR_GO, ST_RCOR_WAIT,
        ST_GYRO, ST_PRED, ST_MULA, ST_MULB, ST_SUM, ST_CLAMP, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [16:0] blend_reg;
    logic [15:0] step_reg;

    // latched sample and working values
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [15:0]              mag_reg;
    logic [31:0]              sq_reg;
    logic signed [ANG_W-1:0]  pacc_reg, racc_reg;
    logic signed [EST_W-1:0]  pest_reg, rest_reg;
    logic signed [EST_W-1:0]  pred_reg;
    logic signed [44:0]       prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     axis_reg;   // 0 pitch, 1 roll
    logic                     mvalid_reg;
    logic signed [16:0]       mpitch_reg, mroll_reg;

    // shared multiplier
    logic signed [26:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [44:0] mul_p;

    logic [16:0]             weight;
    logic [16:0]             weight_inv;
    logic signed [15:0]      gyro_sel;
    logic signed [EST_W-1:0] old_sel;
    logic signed [ANG_W-1:0] acc_sel;
    logic signed [SUM_W-1:0] pred_wide;

    // submodule hookup
    logic               root_start, root_done;
    logic [15:0]        root_val;
    logic [31:0]        radicand;
    logic               cor_start, cor_done;
    logic signed [16:0] cor_y, cor_x;
    logic signed [ANG_W-1:0] cor_angle;

    // clamp alpha to one; 1 - alpha fits 17 bits
    assign weight     = (blend_reg > WEIGHT_ONE) ? WEIGHT_ONE : blend_reg;
    assign weight_inv = WEIGHT_ONE - weight;

    assign gyro_sel = axis_reg ? gy_reg : gx_reg;
    assign old_sel  = axis_reg ? rest_reg : pest_reg;
    assign acc_sel  = axis_reg ? racc_reg : pacc_reg;

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_SQX: begin
                mul_a = 27'(ax_reg);
                mul_b = 18'(ax_reg);
            end
            ST_SQZ: begin
                mul_a = 27'(az_reg);
                mul_b = 18'(az_reg);
            end
            ST_GYRO: begin
                mul_a = 27'(gyro_sel);
                mul_b = $signed({2'b00, step_reg});
            end
            ST_MULA: begin
                mul_a = 27'(pred_reg);
                mul_b = $signed({1'b0, weight});
            end
            ST_MULB: begin
                mul_a = acc_sel;
                mul_b = $signed({1'b0, weight_inv});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 45'(mul_a) * 45'(mul_b);

    // old estimate plus rounded gyro increment
    assign pred_wide = SUM_W'(old_sel) + ((SUM_W'(prod_reg) + SUM_W'(128)) >>> 8);

    assign radicand   = sq_reg + prod_reg[31:0];
    assign root_start = (state_reg == ST_ROOT_GO);
    assign cor_start  = (state_reg == ST_PCOR_GO) || (state_reg == ST_RCOR_GO);

    // pitch: atan2(ay, mag); roll: atan2(-ax, az)
    always_comb begin
        if (state_reg == ST_RCOR_GO) begin
            cor_y = -17'(ax_reg);
            cor_x = 17'(az_reg);
        end else begin
            cor_y = 17'(ay_reg);
            cor_x = $signed({1'b0, mag_reg});
        end
    end

    ictf_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (radicand),
        .root     (root_val),
        .done     (root_done)
    );

    ictf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .y_in    (cor_y),
        .x_in    (cor_x),
        .angle   (cor_angle),
        .done    (cor_done)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer, working registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            blend_reg  <= BLEND_RESET;
            step_reg   <= STEP_RESET;
            pest_reg   <= '0;
            rest_reg   <= '0;
            axis_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            // register writes; unknown indexes drop
            if (cfg_valid) begin
                case (cfg_index)
                    REG_BLEND_WEIGHT: blend_reg <= cfg_data;
                    REG_GYRO_STEP:    step_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            // load a new result when the register frees up, else drop it on transfer
            if (state_reg == ST_OUT && (!mvalid_reg || m_ready)) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ax_reg    <= s_accel_x;
                        ay_reg    <= s_accel_y;
                        az_reg    <= s_accel_z;
                        gx_reg    <= s_gyro_x;
                        gy_reg    <= s_gyro_y;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQZ;
                end
                ST_SQZ: begin
                    sq_reg    <= prod_reg[31:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_ROOT_GO;
                end
                ST_ROOT_GO: begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT: begin
                    if (root_done) begin
                        mag_reg   <= root_val;
                        state_reg <= ST_PCOR_GO;
                    end
                end
                ST_PCOR_GO: begin
                    state_reg <= ST_PCOR_WAIT;
                end
                ST_PCOR_WAIT: begin
                    if (cor_done) begin
                        pacc_reg  <= cor_angle;
                        state_reg <= ST_RCOR_GO;
                    end
                end
                ST_RCOR_GO: begin
                    state_reg <= ST_RCOR_WAIT;
                end
                ST_RCOR_WAIT: begin
                    if (cor_done) begin
                        racc_reg  <= cor_angle;
                        axis_reg  <= 1'b0;
                        state_reg <= ST_GYRO;
                    end
                end
                ST_GYRO: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_PRED;
                end
                ST_PRED: begin
                    pred_reg  <= sat_est(pred_wide);
                    state_reg <= ST_MULA;
                end
                ST_MULA: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MULB;
                end
                ST_MULB: begin
                    // start the sum with the rounding half
                    sum_reg   <= SUM_W'(prod_reg) + SUM_W'(32768);
                    prod_reg  <= mul_p;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sum_reg   <= sum_reg + SUM_W'(prod_reg);
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    if (axis_reg) begin
                        rest_reg  <= sat_est(sum_reg >>> 16);
                        state_reg <= ST_OUT;
                    end else begin
                        pest_reg  <= sat_est(sum_reg >>> 16);
                        axis_reg  <= 1'b1;
                        state_reg <= ST_GYRO;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!mvalid_reg || m_ready) begin
                        mpitch_reg <= pest_reg[EST_W-1:9];
                        mroll_reg  <= rest_reg[EST_W-1:9];
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = mvalid_reg;
    assign m_pitch_angle = mpitch_reg;
    assign m_roll_angle  = mroll_reg;

endmodule
